/* rtl/bps_pkg.sv */
// package for the beep pattern sequencer: request codes, register indexes,
// pattern rom and the sequencer state record; depends on nothing
package bps_pkg;

    localparam int ROM_ROWS = 9;
    localparam int ROM_COLS = 20;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_NORMAL_PERIOD = 2'd0,
        CFG_ALARM_LOW     = 2'd1,
        CFG_ALARM_HIGH    = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    localparam logic [3:0] PAT_FIRST = 4'd1;
    localparam logic [3:0] PAT_ALARM = 4'd9;

    localparam logic [7:0] NORMAL_PERIOD_RST = 8'd1;
    localparam logic [7:0] ALARM_LOW_RST     = 8'd3;
    localparam logic [7:0] ALARM_HIGH_RST    = 8'd1;

    // step lengths in ticks; zero ends a pattern save at odd alarm steps
    localparam logic [11:0] ROM_TABLE [ROM_ROWS][ROM_COLS] = '{
        '{12'd1000, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd2000, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd3000, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd1000, 12'd1000, 12'd1000, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0},
        '{12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0},
        '{12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000,
          12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0},
        '{12'd1000, 12'd1000, 12'd3000, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
          12'd0},
        '{12'd500, 12'd500, 12'd500, 12'd500, 12'd500, 12'd500, 12'd500, 12'd500,
          12'd500, 12'd500, 12'd500, 12'd500, 12'd500, 12'd500, 12'd0, 12'd0,
          12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd1000, 12'd0, 12'd1000, 12'd0, 12'd1000, 12'd0, 12'd1000, 12'd0,
          12'd1000, 12'd0, 12'd1000, 12'd0, 12'd1000, 12'd0, 12'd1000, 12'd0,
          12'd1000, 12'd0, 12'd1000, 12'd1}
    };

    typedef struct packed {
        logic        active;
        logic [3:0]  pattern_sel;
        logic [4:0]  step_index;
        logic [11:0] step_tick_count;
        logic        alarm_mode;
        logic [7:0]  tone_period;
        logic [7:0]  tone_count;
        logic        pin_level;
    } t_seq_state;

    typedef struct packed {
        logic [7:0] normal_period;
        logic [7:0] alarm_low;
        logic [7:0] alarm_high;
    } t_periods;

    // past the stored entries or outside the patterns reads as zero
    function automatic logic [11:0] rom_read(logic [3:0] sel, logic [5:0] idx);
        logic [11:0] val;
        val = '0;
        if (sel >= PAT_FIRST && sel <= PAT_ALARM && idx < 6'(ROM_COLS)) begin
            val = ROM_TABLE[sel - PAT_FIRST][idx[4:0]];
        end
        return val;
    endfunction

endpackage

/* rtl/bps_if.sv */
// handshake channel interfaces for the beep pattern sequencer
// depends on nothing
interface bps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] pattern_code;
    modport source (output valid, output req_type, output pattern_code, input ready);
    modport sink (input valid, input req_type, input pattern_code, output ready);
endinterface

interface bps_out_if;
    logic valid;
    logic ready;
    logic horn_level;
    logic busy_res;
    modport source (output valid, output horn_level, output busy_res, input ready);
    modport sink (input valid, input horn_level, input busy_res, output ready);
endinterface

interface bps_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/bps_step.sv */
// next-state logic of the sequencer for one item
// depends on bps_pkg
module bps_step #(
    parameter int MAX_STEPS = 20
) (
    input  bps_pkg::t_seq_state i_state,
    input  logic [1:0]          i_req_type,
    input  logic [3:0]          i_pattern_code,
    input  bps_pkg::t_periods   i_periods,
    output bps_pkg::t_seq_state o_state
);

    localparam logic [5:0] MaxSteps = 6'(MAX_STEPS);

    logic [5:0]  step1;
    logic [5:0]  step2;
    logic [5:0]  new_step;
    logic [11:0] len_cur;
    logic [11:0] len1;
    logic [11:0] len2;
    logic [11:0] tick_inc;
    logic        end1;
    logic        end2;
    logic        skip_odd;
    logic        finish;
    logic [7:0]  load_period;
    logic        load_silent;
    logic [7:0]  tone_inc;

    assign step1    = {1'b0, i_state.step_index} + 6'd1;
    assign step2    = step1 + 6'd1;
    assign len_cur  = bps_pkg::rom_read(i_state.pattern_sel, {1'b0, i_state.step_index});
    assign len1     = bps_pkg::rom_read(i_state.pattern_sel, step1);
    assign len2     = bps_pkg::rom_read(i_state.pattern_sel, step2);
    assign tick_inc = i_state.step_tick_count + 12'd1;
    assign end1     = (step1 >= MaxSteps) || (len1 == '0);
    assign end2     = (step2 >= MaxSteps) || (len2 == '0);
    assign skip_odd = i_state.alarm_mode && (step1 < MaxSteps) && step1[0];
    assign finish   = end1 && (!skip_odd || end2);
    assign new_step = end1 ? step2 : step1;

    // tone for the step being entered
    always_comb begin
        load_silent = 1'b0;
        load_period = i_periods.normal_period;
        if (i_state.alarm_mode) begin
            load_period = new_step[1] ? i_periods.alarm_high : i_periods.alarm_low;
        end else if (new_step[0]) begin
            load_silent = 1'b1;
            load_period = '0;
        end
    end

    always_comb begin
        o_state  = i_state;
        tone_inc = '0;
        unique case (bps_pkg::t_req'(i_req_type))
            bps_pkg::REQ_TICK: begin
                if (i_state.active) begin
                    o_state.step_tick_count = tick_inc;
                    if (tick_inc >= len_cur && finish) begin
                        o_state.active          = 1'b0;
                        o_state.pattern_sel     = '0;
                        o_state.step_index      = '0;
                        o_state.step_tick_count = '0;
                        o_state.alarm_mode      = 1'b0;
                        o_state.tone_period     = '0;
                        o_state.pin_level       = 1'b0;
                    end else begin
                        if (tick_inc >= len_cur) begin
                            o_state.step_tick_count = '0;
                            o_state.step_index      = new_step[4:0];
                            o_state.tone_period     = load_period;
                            if (load_silent) begin
                                o_state.pin_level = 1'b0;
                            end else begin
                                o_state.tone_count = '0;
                            end
                        end
                        if (o_state.tone_period != '0) begin
                            tone_inc = o_state.tone_count + 8'd1;
                            if (tone_inc >= o_state.tone_period) begin
                                o_state.tone_count = '0;
                                o_state.pin_level  = !o_state.pin_level;
                            end else begin
                                o_state.tone_count = tone_inc;
                            end
                        end
                    end
                end
            end
            bps_pkg::REQ_START: begin
                if (i_pattern_code >= bps_pkg::PAT_FIRST
                        && i_pattern_code <= bps_pkg::PAT_ALARM) begin
                    o_state.active          = 1'b1;
                    o_state.pattern_sel     = i_pattern_code;
                    o_state.step_index      = '0;
                    o_state.step_tick_count = '0;
                    o_state.alarm_mode      = (i_pattern_code == bps_pkg::PAT_ALARM);
                    o_state.tone_period     = (i_pattern_code == bps_pkg::PAT_ALARM)
                                              ? i_periods.alarm_low
                                              : i_periods.normal_period;
                    o_state.tone_count      = '0;
                end
            end
            bps_pkg::REQ_STOP: begin
                o_state.active          = 1'b0;
                o_state.pattern_sel     = '0;
                o_state.step_index      = '0;
                o_state.step_tick_count = '0;
                o_state.alarm_mode      = 1'b0;
                o_state.tone_period     = '0;
                o_state.pin_level       = 1'b0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

/* rtl/bps_out_buf.sv */
// two-entry result buffer between the sequencer and the output channel
// depends on bps_if
module bps_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [1:0]       i_data,
    output logic             o_can_push,
    bps_out_if.source        o_out
);

    logic [1:0] r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       pop;

    assign o_can_push     = (r_count != 2'd2);
    assign pop            = o_out.valid && o_out.ready;
    assign o_out.valid    = (r_count != 2'd0);
    assign o_out.horn_level = r_buf[r_rd_ptr][1];
    assign o_out.busy_res   = r_buf[r_rd_ptr][0];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/beep_pattern_sequencer_top.sv */
// top level of the beep pattern sequencer: period registers, sequencer state
// and result buffer; depends on bps_pkg, bps_if, bps_step and bps_out_buf

// plays a buzzer pin from nine fixed on/off patterns. each input item is a
// tick, a start (pattern codes 1 to 9, others ignored) or a stop, and gives
// exactly one result item: the pin level and a busy flag after that item.
// an item's state update is done in the cycle it is accepted and the
// result lands in a two-entry output buffer, so one item per cycle is
// sustained while the output side keeps up, and input ready drops only
// when both buffer entries hold results not yet taken.
// the three tone periods are written through the configuration channel,
// which is always ready, and are sampled when a step's tone is loaded.
module beep_pattern_sequencer_top #(
    parameter int MAX_STEPS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bps_in_if.sink    i_in,
    bps_cfg_if.sink   i_cfg,
    bps_out_if.source o_out
);

    bps_pkg::t_seq_state r_state;
    bps_pkg::t_seq_state n_state;
    bps_pkg::t_periods   r_periods;
    logic                accept;
    logic                can_push;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = can_push;
    assign accept      = i_in.valid && can_push;

    // period registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods.normal_period <= bps_pkg::NORMAL_PERIOD_RST;
            r_periods.alarm_low     <= bps_pkg::ALARM_LOW_RST;
            r_periods.alarm_high    <= bps_pkg::ALARM_HIGH_RST;
        end else if (i_cfg.valid) begin
            unique case (bps_pkg::t_cfg_idx'(i_cfg.index))
                bps_pkg::CFG_NORMAL_PERIOD: r_periods.normal_period <= i_cfg.data;
                bps_pkg::CFG_ALARM_LOW:     r_periods.alarm_low     <= i_cfg.data;
                bps_pkg::CFG_ALARM_HIGH:    r_periods.alarm_high    <= i_cfg.data;
                default: begin
                    // unused index, nothing to write
                end
            endcase
        end
    end

    // next sequencer state for the offered item
    bps_step #(
        .MAX_STEPS (MAX_STEPS)
    ) u_step (
        .i_state        (r_state),
        .i_req_type     (i_in.req_type),
        .i_pattern_code (i_in.pattern_code),
        .i_periods      (r_periods),
        .o_state        (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result of the accepted item goes straight into the buffer
    bps_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     ({n_state.pin_level, n_state.active}),
        .o_can_push (can_push),
        .o_out      (o_out)
    );

endmodule
